// File: rtl/npcm_pkg.sv
package npcm_pkg;

  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;
  localparam int CHAN_W     = 8;
  localparam int RGB_W      = 24;
  localparam int COLOR_W    = 32;
  localparam int SQ_W       = 16;
  localparam int DIST_W     = 18;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MAP  = 1'b1
  } npcm_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USED_COLORS = 1'b0,
    CFG_SKIP_FIRST  = 1'b1
  } npcm_cfg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_POST
  } npcm_state_e;

  typedef struct packed {
    logic             init;
    logic             probe_valid;
    logic [IDX_W-1:0] probe_idx;
    logic [IDX_W-1:0] start_idx;
  } npcm_ctrl_t;

endpackage

// File: rtl/npcm_if.sv
interface npcm_in_if;
  import npcm_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [IDX_W-1:0]   entry_index;
  logic [COLOR_W-1:0] color;

  modport source (output valid, output op, output entry_index, output color, input ready);
  modport sink   (input valid, input op, input entry_index, input color, output ready);
endinterface

interface npcm_out_if;
  import npcm_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] palette_index;

  modport source (output valid, output palette_index, input ready);
  modport sink   (input valid, input palette_index, output ready);
endinterface

// File: rtl/npcm_cell.sv
module npcm_cell (
  input  logic                     clk_i,
  input  logic                     shift_i,
  input  logic                     load_i,
  input  logic [npcm_pkg::RGB_W-1:0] load_rgb_i,
  input  logic [npcm_pkg::RGB_W-1:0] next_rgb_i,
  output logic [npcm_pkg::RGB_W-1:0] rgb_o
);
  import npcm_pkg::*;

  logic [RGB_W-1:0] rgb_q;
  logic [RGB_W-1:0] rgb_d;

  always_comb begin
    rgb_d = rgb_q;
    if (load_i) begin
      rgb_d = load_rgb_i;
    end else if (shift_i) begin
      rgb_d = next_rgb_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign rgb_o = rgb_q;

endmodule

// File: rtl/npcm_dist.sv
module npcm_dist (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  npcm_pkg::npcm_ctrl_t        ctrl_i,
  input  logic [npcm_pkg::RGB_W-1:0]  rgb_i,
  input  logic [npcm_pkg::RGB_W-1:0]  pixel_i,
  output logic [npcm_pkg::IDX_W-1:0]  best_o
);
  import npcm_pkg::*;

  function automatic logic [SQ_W-1:0] diff_sq(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  logic              s1_valid_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic [SQ_W-1:0]   sq_r_q, sq_g_q, sq_b_q;
  logic [DIST_W-1:0] best_dist_q, best_dist_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [DIST_W-1:0] dist_sum;
  logic              better;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= ctrl_i.probe_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= ctrl_i.probe_idx;
    sq_r_q   <= diff_sq(rgb_i[23:16], pixel_i[23:16]);
    sq_g_q   <= diff_sq(rgb_i[15:8],  pixel_i[15:8]);
    sq_b_q   <= diff_sq(rgb_i[7:0],   pixel_i[7:0]);
  end

  assign dist_sum = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);
  assign better   = s1_valid_q && (dist_sum < best_dist_q);

  always_comb begin
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    if (ctrl_i.init) begin
      best_dist_d = '1;
      best_idx_d  = ctrl_i.start_idx;
    end else if (better) begin
      best_dist_d = dist_sum;
      best_idx_d  = s1_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    best_dist_q <= best_dist_d;
    best_idx_q  <= best_idx_d;
  end

  assign best_o = best_idx_q;

endmodule

// File: rtl/nearest_palette_color_mapper.sv
// Nearest palette color mapper.
// in_i carries items: op OP_LOAD writes the low 24 bits of color into palette
// slot entry_index (slots at or above PALETTE_DEPTH are dropped); op OP_MAP
// maps the ARGB pixel in color to a palette index returned on out_o.
// A pixel with alpha zero maps to index 0. Otherwise the slots from the start
// slot (1 when skip_first_entry is set, else 0) up to used_colors-1 are
// searched for the least squared RGB distance; ties keep the lower index.
// The palette sits in a ring of PALETTE_DEPTH cells that rotates once per map
// item past a single distance unit, and in_i takes no new item until a map
// item's result is registered; an alpha-zero pixel skips the rotation and a
// load leaves the block idle.
// Configuration writes on cfg_we_i take effect at once; issue them when idle.
// Reset clears the control registers and handshake state; palette contents are
// undefined until loaded. A stalled out_o holds its result; the block keeps
// the next result internally and stops taking items until out_o drains.
module nearest_palette_color_mapper #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [npcm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [npcm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  npcm_in_if.sink                          in_i,
  npcm_out_if.source                       out_o
);
  import npcm_pkg::*;

  npcm_state_e       state_q, state_d;
  logic [CNT_W-1:0]  used_q;
  logic              skip_q;
  logic [CNT_W-1:0]  scan_cnt_q, scan_cnt_d;
  logic [RGB_W-1:0]  pix_q;
  logic              zero_q, zero_d;
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;

  logic              in_xfer, load_xfer, map_xfer, alpha_zero;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  start_idx;
  logic [IDX_W-1:0]  best_idx;
  npcm_ctrl_t        ctrl;
  logic [RGB_W-1:0]  ring [PALETTE_DEPTH];

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign load_xfer  = in_xfer && (in_i.op == OP_LOAD);
  assign map_xfer   = in_xfer && (in_i.op == OP_MAP);
  assign alpha_zero = (in_i.color[31:24] == '0);

  assign count     = (used_q > CNT_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH) : used_q;
  assign start_idx = {{(IDX_W-1){1'b0}}, skip_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      skip_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_USED_COLORS: used_q <= cfg_data_i[CNT_W-1:0];
        CFG_SKIP_FIRST:  skip_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_ring
    localparam int NEXT = (i + 1) % PALETTE_DEPTH;
    npcm_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (state_q == S_SCAN),
      .load_i     (load_xfer && (in_i.entry_index == IDX_W'(i))),
      .load_rgb_i (in_i.color[RGB_W-1:0]),
      .next_rgb_i (ring[NEXT]),
      .rgb_o      (ring[i])
    );
  end

  always_comb begin
    ctrl.init        = map_xfer && !alpha_zero;
    ctrl.start_idx   = start_idx;
    ctrl.probe_idx   = scan_cnt_q[IDX_W-1:0];
    ctrl.probe_valid = (state_q == S_SCAN) && (scan_cnt_q >= CNT_W'(start_idx))
                       && (scan_cnt_q < count);
  end

  npcm_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .rgb_i   (ring[0]),
    .pixel_i (pix_q),
    .best_o  (best_idx)
  );

  always_ff @(posedge clk_i) begin
    if (map_xfer) begin
      pix_q <= in_i.color[RGB_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    scan_cnt_d  = scan_cnt_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_idx_d   = out_idx_q;
    case (state_q)
      S_IDLE: begin
        if (map_xfer) begin
          zero_d  = alpha_zero;
          state_d = alpha_zero ? S_POST : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt_q == CNT_W'(PALETTE_DEPTH - 1)) begin
          scan_cnt_d = '0;
          state_d    = S_DRAIN;
        end else begin
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = S_POST;
      end
      S_POST: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_idx_d   = zero_q ? '0 : best_idx;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_cnt_q  <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q <= out_idx_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.palette_index = out_idx_q;

  a_zero_alpha_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (map_xfer && alpha_zero) |=> (state_q == S_POST) && zero_q)
    else $error("alpha-zero pixel did not go straight to result");

  a_out_from_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_POST))
    else $error("result appeared outside the post state");

  a_drain_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && (scan_cnt_q == CNT_W'(PALETTE_DEPTH - 1))
      |=> (state_q == S_DRAIN) && (scan_cnt_q == '0))
    else $error("scan did not end after a full ring rotation");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SCAN) |-> (scan_cnt_q == '0))
    else $error("scan counter not parked outside a scan");

endmodule
